/* src/mtpa_pkg.sv */
`default_nettype none
package mtpa_pkg;

  // field widths
  localparam int CUR_W  = 16;
  localparam int CEIL_W = CUR_W - 1;
  localparam int IND_W  = 20;
  localparam int FLUX_W = 32;
  localparam int DATA_W = 32;

  // datapath widths
  localparam int MS2_W  = 2 * CUR_W;
  localparam int D2_W   = 2 * IND_W;
  localparam int KP_W   = IND_W + MS2_W;
  localparam int F2_W   = 2 * FLUX_W;
  localparam int K_W    = D2_W + MS2_W + 3;
  localparam int SUM_W  = ((K_W > F2_W) ? K_W : F2_W) + 1;
  localparam int RAD_W  = ((SUM_W + 7) / 8) * 8;
  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 1;
  localparam int DV_W   = IND_W + 2;
  localparam int ID_W   = CUR_W + 2;
  localparam int IQ_W   = CUR_W + 1;

  // root or quotient bits resolved per stage
  localparam int SPS       = 4;
  localparam int SQ1_N     = RAD_W / (2 * SPS);
  localparam int SQ2_N     = (CUR_W + SPS - 1) / SPS;
  localparam int SQ2_STEPS = SQ2_N * SPS;
  localparam int DIV_N     = SQ2_N;

  // stage map
  localparam int ST_IN   = 0;
  localparam int ST_MUL  = ST_IN + 1;
  localparam int ST_KMUL = ST_MUL + 1;
  localparam int ST_SUM  = ST_KMUL + 1;
  localparam int ST_SQ1  = ST_SUM + 1;
  localparam int ST_DIVS = ST_SQ1 + SQ1_N;
  localparam int ST_DIV  = ST_DIVS + 1;
  localparam int ST_QSQ  = ST_DIV + DIV_N;
  localparam int ST_RAD2 = ST_QSQ + 1;
  localparam int ST_SQ2  = ST_RAD2 + 1;
  localparam int ST_LIM  = ST_SQ2 + SQ2_N;
  localparam int ST_LSQ  = ST_LIM + 1;
  localparam int ST_RAD3 = ST_LSQ + 1;
  localparam int ST_SQ3  = ST_RAD3 + 1;
  localparam int ST_OUT  = ST_SQ3 + SQ2_N;
  localparam int NST     = ST_OUT + 1;

  // register map
  localparam int REG_IDX_W = 3;
  localparam int ADDR_W    = REG_IDX_W + 2;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_MTPA_ON,
    REG_D_IND,
    REG_Q_IND,
    REG_FLUX,
    REG_CEILING
  } reg_idx_t;

  localparam logic [CEIL_W-1:0] CEIL_RST = CEIL_W'(32767);

endpackage
`default_nettype wire

/* src/mtpa_intf.sv */
`default_nettype none
interface mtpa_req_if;
  logic                              valid;
  logic                              ready;
  logic signed [mtpa_pkg::CUR_W-1:0] stator_current_request;
  logic signed [mtpa_pkg::CUR_W-1:0] weakening_offset;

  modport source (output valid, output stator_current_request, output weakening_offset,
                  input ready);
  modport sink (input valid, input stator_current_request, input weakening_offset,
                output ready);
endinterface

interface mtpa_rsp_if;
  logic                              valid;
  logic                              ready;
  logic signed [mtpa_pkg::CUR_W-1:0] d_current_ref;
  logic signed [mtpa_pkg::CUR_W-1:0] q_current_ref;

  modport source (output valid, output d_current_ref, output q_current_ref, input ready);
  modport sink (input valid, input d_current_ref, input q_current_ref, output ready);
endinterface
`default_nettype wire

/* src/mtpa_current_reference.sv */
// MTPA current reference with circular current limit.
// Request channel (req): signed stator current magnitude request and a
// non-positive field-weakening d-axis offset, both LSB 1/256 A.
// Response channel (rsp): limited d and q current references, LSB 1/256 A.
// Both channels use valid/ready; a transaction completes when both are high.
// Config over the APB-style port: mtpa_on, Ld, Lq, flux, current ceiling at
// byte addresses 0, 4, 8, 12, 16. Write only while no transaction is in flight.
// A result passes through 33 register stages. Throughput: one transaction
// per cycle while rsp is not stalled; the depth is set by the 40-bit root of
// psi^2 + 8*dL^2*Is^2 (4 root bits per stage) and the 16-bit quotient and
// two 16-bit roots after it.
// Each stage holds its data while the next stage is full and stalled, so a
// stalled rsp backs the pipeline up stage by stage; empty stages keep
// taking requests until the pipe is full.
// Reset clears all stage valid bits and loads register defaults (MTPA off,
// inductances and flux zero, ceiling 32767).
`default_nettype none
module mtpa_current_reference (
  input  wire logic                              clk,
  input  wire logic                              rst,
  mtpa_req_if.sink                               req,
  mtpa_rsp_if.source                             rsp,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [mtpa_pkg::ADDR_W-1:0]       paddr,
  input  wire logic [mtpa_pkg::DATA_W-1:0]       pwdata,
  output logic      [mtpa_pkg::DATA_W-1:0]       prdata,
  output logic                                   pready
);

  typedef struct packed {
    logic                               on;
    logic [mtpa_pkg::IND_W-1:0]         ld;
    logic [mtpa_pkg::IND_W-1:0]         lq;
    logic [mtpa_pkg::FLUX_W-1:0]        flux;
    logic [mtpa_pkg::CEIL_W-1:0]        ceil;
  } cfg_t;

  // everything one item carries down the pipe
  typedef struct packed {
    logic signed [mtpa_pkg::CUR_W-1:0]  s;
    logic signed [mtpa_pkg::CUR_W-1:0]  off;
    logic                               byp;
    logic [mtpa_pkg::CUR_W-1:0]         mag;
    logic [mtpa_pkg::IND_W-1:0]         d;
    logic [mtpa_pkg::DV_W-1:0]          dv;
    logic [mtpa_pkg::D2_W-1:0]          d2;
    logic [mtpa_pkg::MS2_W-1:0]         ms2;
    logic [mtpa_pkg::F2_W-1:0]          f2;
    logic [mtpa_pkg::KP_W-1:0]          kh;
    logic [mtpa_pkg::KP_W-1:0]          kl;
    logic [mtpa_pkg::RAD_W-1:0]         rad;
    logic [mtpa_pkg::REM_W-1:0]         rem;
    logic [mtpa_pkg::ROOT_W-1:0]        root;
    logic [mtpa_pkg::CUR_W-1:0]         q;
    logic [mtpa_pkg::MS2_W-1:0]         qsq;
    logic [mtpa_pkg::MS2_W-1:0]         lsq;
    logic [mtpa_pkg::MS2_W-1:0]         msq;
    logic signed [mtpa_pkg::CUR_W-1:0]  id;
    logic signed [mtpa_pkg::IQ_W-1:0]   iq;
  } pipe_t;

  cfg_t cfg;

  // ---------------------------------------------------------------- config
  logic                 wr_en;
  mtpa_pkg::reg_idx_t   reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = mtpa_pkg::reg_idx_t'(paddr[mtpa_pkg::ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.on   <= 1'b0;
      cfg.ld   <= '0;
      cfg.lq   <= '0;
      cfg.flux <= '0;
      cfg.ceil <= mtpa_pkg::CEIL_RST;
    end else if (wr_en) begin
      case (reg_idx)
        mtpa_pkg::REG_MTPA_ON: cfg.on   <= pwdata[0];
        mtpa_pkg::REG_D_IND:   cfg.ld   <= pwdata[mtpa_pkg::IND_W-1:0];
        mtpa_pkg::REG_Q_IND:   cfg.lq   <= pwdata[mtpa_pkg::IND_W-1:0];
        mtpa_pkg::REG_FLUX:    cfg.flux <= pwdata[mtpa_pkg::FLUX_W-1:0];
        mtpa_pkg::REG_CEILING: cfg.ceil <= pwdata[mtpa_pkg::CEIL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      mtpa_pkg::REG_MTPA_ON: prdata = mtpa_pkg::DATA_W'(cfg.on);
      mtpa_pkg::REG_D_IND:   prdata = mtpa_pkg::DATA_W'(cfg.ld);
      mtpa_pkg::REG_Q_IND:   prdata = mtpa_pkg::DATA_W'(cfg.lq);
      mtpa_pkg::REG_FLUX:    prdata = mtpa_pkg::DATA_W'(cfg.flux);
      mtpa_pkg::REG_CEILING: prdata = mtpa_pkg::DATA_W'(cfg.ceil);
      default:               prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- helpers
  // one restoring square-root step: two radicand bits in, one root bit out
  function automatic pipe_t sq_step(pipe_t x);
    logic [mtpa_pkg::REM_W+1:0] r2;
    logic [mtpa_pkg::REM_W+1:0] tr;
    pipe_t                      y;
    y  = x;
    r2 = {x.rem, x.rad[mtpa_pkg::RAD_W-1 -: 2]};
    tr = (mtpa_pkg::REM_W+2)'({x.root, 2'b01});
    if (r2 >= tr) begin
      y.rem  = mtpa_pkg::REM_W'(r2 - tr);
      y.root = {x.root[mtpa_pkg::ROOT_W-2:0], 1'b1};
    end else begin
      y.rem  = mtpa_pkg::REM_W'(r2);
      y.root = {x.root[mtpa_pkg::ROOT_W-2:0], 1'b0};
    end
    y.rad = x.rad << 2;
    return y;
  endfunction

  // one restoring division step for quotient bit b
  function automatic pipe_t div_step(pipe_t x, int b);
    logic [mtpa_pkg::REM_W-1:0] sh;
    pipe_t                      y;
    y  = x;
    sh = mtpa_pkg::REM_W'(x.dv) << b;
    if (x.rem >= sh) begin
      y.rem = x.rem - sh;
      y.q   = x.q | (mtpa_pkg::CUR_W'(1) << b);
    end
    return y;
  endfunction

  function automatic pipe_t stage_fn(int k, pipe_t x, cfg_t c);
    pipe_t                               y;
    int                                  b;
    logic [mtpa_pkg::CEIL_W-1:0]         idm;
    logic signed [mtpa_pkg::IQ_W-1:0]    mr;
    logic signed [mtpa_pkg::ID_W-1:0]    idw;
    logic signed [mtpa_pkg::ID_W-1:0]    mxs;
    y = x;
    if (k == mtpa_pkg::ST_IN) begin
      y.mag = x.s[mtpa_pkg::CUR_W-1] ? mtpa_pkg::CUR_W'(-x.s) : mtpa_pkg::CUR_W'(x.s);
      y.byp = !c.on || (c.ld == '0) || (c.lq == '0) || (c.lq <= c.ld);
      y.d   = c.lq - c.ld;
    end else if (k == mtpa_pkg::ST_MUL) begin
      y.d2  = mtpa_pkg::D2_W'(x.d) * mtpa_pkg::D2_W'(x.d);
      y.ms2 = mtpa_pkg::MS2_W'(x.mag) * mtpa_pkg::MS2_W'(x.mag);
      y.f2  = mtpa_pkg::F2_W'(c.flux) * mtpa_pkg::F2_W'(c.flux);
    end else if (k == mtpa_pkg::ST_KMUL) begin
      // dL^2 * Is^2 as two partial products
      y.kh = mtpa_pkg::KP_W'(x.d2[mtpa_pkg::D2_W-1:mtpa_pkg::IND_W]) *
             mtpa_pkg::KP_W'(x.ms2);
      y.kl = mtpa_pkg::KP_W'(x.d2[mtpa_pkg::IND_W-1:0]) * mtpa_pkg::KP_W'(x.ms2);
    end else if (k == mtpa_pkg::ST_SUM) begin
      y.rad  = mtpa_pkg::RAD_W'(x.f2) +
               (mtpa_pkg::RAD_W'(x.kh) << (mtpa_pkg::IND_W + 3)) +
               (mtpa_pkg::RAD_W'(x.kl) << 3);
      y.rem  = '0;
      y.root = '0;
    end else if (k >= mtpa_pkg::ST_SQ1 && k < mtpa_pkg::ST_DIVS) begin
      for (int j = 0; j < mtpa_pkg::SPS; j++) y = sq_step(y);
    end else if (k == mtpa_pkg::ST_DIVS) begin
      // numerator T - psi, floored at zero
      y.rem = (mtpa_pkg::REM_W'(x.root) >= mtpa_pkg::REM_W'(c.flux)) ?
              mtpa_pkg::REM_W'(x.root) - mtpa_pkg::REM_W'(c.flux) : '0;
      y.dv  = {x.d, 2'b00};
      y.q   = '0;
    end else if (k >= mtpa_pkg::ST_DIV && k < mtpa_pkg::ST_QSQ) begin
      for (int j = 0; j < mtpa_pkg::SPS; j++) begin
        b = mtpa_pkg::CUR_W - 1 - mtpa_pkg::SPS * (k - mtpa_pkg::ST_DIV) - j;
        if (b >= 0) y = div_step(y, b);
      end
    end else if (k == mtpa_pkg::ST_QSQ) begin
      y.qsq = mtpa_pkg::MS2_W'(x.q) * mtpa_pkg::MS2_W'(x.q);
    end else if (k == mtpa_pkg::ST_RAD2) begin
      y.rad  = mtpa_pkg::RAD_W'((x.ms2 >= x.qsq) ? x.ms2 - x.qsq : '0) <<
               (mtpa_pkg::RAD_W - 2 * mtpa_pkg::SQ2_STEPS);
      y.rem  = '0;
      y.root = '0;
    end else if (k >= mtpa_pkg::ST_SQ2 && k < mtpa_pkg::ST_LIM) begin
      for (int j = 0; j < mtpa_pkg::SPS; j++) y = sq_step(y);
    end else if (k == mtpa_pkg::ST_LIM) begin
      mr   = $signed({1'b0, x.root[mtpa_pkg::CUR_W-1:0]});
      y.iq = x.byp ? mtpa_pkg::IQ_W'(x.s) : (x.s[mtpa_pkg::CUR_W-1] ? -mr : mr);
      idw  = mtpa_pkg::ID_W'(x.off);
      if (!x.byp) idw = idw - $signed({2'b00, x.q});
      mxs  = $signed({3'b000, c.ceil});
      if (idw > mxs) idw = mxs;
      else if (idw < -mxs) idw = -mxs;
      y.id = mtpa_pkg::CUR_W'(idw);
    end else if (k == mtpa_pkg::ST_LSQ) begin
      idm   = x.id[mtpa_pkg::CUR_W-1] ? mtpa_pkg::CEIL_W'(-x.id) : mtpa_pkg::CEIL_W'(x.id);
      y.lsq = mtpa_pkg::MS2_W'(idm) * mtpa_pkg::MS2_W'(idm);
      y.msq = mtpa_pkg::MS2_W'(c.ceil) * mtpa_pkg::MS2_W'(c.ceil);
    end else if (k == mtpa_pkg::ST_RAD3) begin
      y.rad  = mtpa_pkg::RAD_W'(x.msq - x.lsq) <<
               (mtpa_pkg::RAD_W - 2 * mtpa_pkg::SQ2_STEPS);
      y.rem  = '0;
      y.root = '0;
    end else if (k >= mtpa_pkg::ST_SQ3 && k < mtpa_pkg::ST_OUT) begin
      for (int j = 0; j < mtpa_pkg::SPS; j++) y = sq_step(y);
    end else begin
      // circle limit on iq
      mr = $signed({1'b0, x.root[mtpa_pkg::CUR_W-1:0]});
      if (x.iq > mr) y.iq = mr;
      else if (x.iq < -mr) y.iq = -mr;
    end
    return y;
  endfunction

  // ---------------------------------------------------------------- pipe
  pipe_t                     st  [mtpa_pkg::NST];
  pipe_t                     nxt [mtpa_pkg::NST];
  logic [mtpa_pkg::NST-1:0]  vld;
  logic [mtpa_pkg::NST-1:0]  rdy;
  pipe_t                     x0;

  always_comb begin
    x0     = '0;
    x0.s   = req.stator_current_request;
    x0.off = req.weakening_offset;
  end

  for (genvar k = 0; k < mtpa_pkg::NST; k++) begin : g_stage
    if (k == 0) begin : g_first
      assign nxt[k] = stage_fn(k, x0, cfg);
      always_ff @(posedge clk) begin
        if (rst) vld[k] <= 1'b0;
        else if (rdy[k]) vld[k] <= req.valid;
      end
    end else begin : g_next
      assign nxt[k] = stage_fn(k, st[k-1], cfg);
      always_ff @(posedge clk) begin
        if (rst) vld[k] <= 1'b0;
        else if (rdy[k]) vld[k] <= vld[k-1];
      end
    end

    // stage takes new data when empty or when its content moves on
    if (k == mtpa_pkg::NST - 1) begin : g_last
      assign rdy[k] = !vld[k] || rsp.ready;
    end else begin : g_mid
      assign rdy[k] = !vld[k] || rdy[k+1];
    end

    always_ff @(posedge clk) begin
      if (rdy[k]) st[k] <= nxt[k];
    end
  end

  assign req.ready         = rdy[0];
  assign rsp.valid         = vld[mtpa_pkg::NST-1];
  assign rsp.d_current_ref = st[mtpa_pkg::NST-1].id;
  assign rsp.q_current_ref = mtpa_pkg::CUR_W'(st[mtpa_pkg::NST-1].iq);

  // ---------------------------------------------------------------- checks
  logic [mtpa_pkg::CUR_W-1:0] d_mag;
  logic [mtpa_pkg::CUR_W-1:0] q_mag;

  assign d_mag = rsp.d_current_ref[mtpa_pkg::CUR_W-1] ?
                 mtpa_pkg::CUR_W'(-rsp.d_current_ref) : mtpa_pkg::CUR_W'(rsp.d_current_ref);
  assign q_mag = rsp.q_current_ref[mtpa_pkg::CUR_W-1] ?
                 mtpa_pkg::CUR_W'(-rsp.q_current_ref) : mtpa_pkg::CUR_W'(rsp.q_current_ref);

  a_reset_empty: assert property (@(posedge clk) rst |=> (vld == '0))
    else $error("pipe not empty after reset");

  a_d_in_limit: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (d_mag <= mtpa_pkg::CUR_W'(cfg.ceil)))
    else $error("d reference beyond ceiling");

  a_q_in_limit: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (q_mag <= mtpa_pkg::CUR_W'(cfg.ceil)))
    else $error("q reference beyond ceiling");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (vld[mtpa_pkg::NST-1] && !rsp.ready) |-> !rdy[0] || !vld[0] ||
    (vld != '1))
    else $error("full pipe still taking requests");

endmodule
`default_nettype wire
